// ===== src/njoin_pkg.sv =====
// ----------------------------------------------------------------------------
// njoin_pkg
// Shared types, codes and configuration decode for the equi-join engine.
// ----------------------------------------------------------------------------
package njoin_pkg;

    localparam int ROWS      = 64;
    localparam int MAX_ARITY = 4;
    localparam int WORD_W    = 32;
    localparam int OUT_COLS  = 2 * MAX_ARITY;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int CNT_W     = $clog2(ROWS + 1);
    localparam int COL_W     = $clog2(MAX_ARITY);
    localparam int OUT_IW    = $clog2(OUT_COLS);
    localparam int OCNT_W    = 4;
    localparam int ARITY_W   = 3;
    localparam int MATCH_W   = 12;
    localparam int CODE_W    = 3;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 12;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MAX_ARITY-1:0][WORD_W-1:0] row_t;
    typedef logic [OUT_COLS-1:0][WORD_W-1:0] out_row_t;

    typedef enum logic [1:0]
    {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_PROBE  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        STAT_JOIN = 2'd0,
        STAT_OK   = 2'd1,
        STAT_FULL = 2'd2,
        STAT_NONE = 2'd3
    } status_t;

    typedef enum logic [CFG_IW-1:0]
    {
        CFG_LEFT_ARITY  = 2'd0,
        CFG_RIGHT_ARITY = 2'd1,
        CFG_RIGHT_MATCH = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    // decoded join setup; the user must keep it fixed for the duration of a probe, the block does not enforce it
    typedef struct packed
    {
        logic [ARITY_W-1:0]                la;
        logic [ARITY_W-1:0]                ra;
        logic [MAX_ARITY-1:0]              linked;
        logic [MAX_ARITY-1:0][COL_W-1:0]   link_col;
    } join_cfg_t;

    function automatic logic [ARITY_W-1:0] eff_arity(input logic [ARITY_W-1:0] a);
        logic [ARITY_W-1:0] r;
        if (a == '0)
            r = ARITY_W'(1);
        else if (a > ARITY_W'(MAX_ARITY))
            r = ARITY_W'(MAX_ARITY);
        else
            r = a;
        return r;
    endfunction

    function automatic join_cfg_t decode_cfg(input logic [ARITY_W-1:0] la_raw,
                                             input logic [ARITY_W-1:0] ra_raw,
                                             input logic [MATCH_W-1:0] match);
        join_cfg_t          jc;
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  lcol;
        jc.la = eff_arity(la_raw);
        jc.ra = eff_arity(ra_raw);
        for (int c = 0; c < MAX_ARITY; c++)
        begin
            code = match[CODE_W*c +: CODE_W];
            lcol = code - CODE_W'(1);
            // codes 5..7 and links past the left arity fall out here
            jc.linked[c]   = (code != '0) && (lcol < jc.la);
            jc.link_col[c] = lcol[COL_W-1:0];
        end
        return jc;
    endfunction

endpackage

// ===== src/njoin_in_if.sv =====
// ----------------------------------------------------------------------------
// njoin_in_if
// Input channel: item kind plus one row of values.
// ----------------------------------------------------------------------------
interface njoin_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;

    modport source (output valid, kind, value_0, value_1, value_2, value_3,
                    input ready);
    modport sink   (input valid, kind, value_0, value_1, value_2, value_3,
                    output ready);
endinterface

// ===== src/njoin_out_if.sv =====
// ----------------------------------------------------------------------------
// njoin_out_if
// Output channel: status, column count, last flag and one output row.
// ----------------------------------------------------------------------------
interface njoin_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         columns;
    logic               last;
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic signed [31:0] out_4;
    logic signed [31:0] out_5;
    logic signed [31:0] out_6;
    logic signed [31:0] out_7;

    modport source (output valid, status, columns, last,
                    out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                    input ready);
    modport sink   (input valid, status, columns, last,
                    out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                    output ready);
endinterface

// ===== src/njoin_store.sv =====
// ----------------------------------------------------------------------------
// njoin_store
// Right row store: one row-wide write port, one registered read port.
// ----------------------------------------------------------------------------
module njoin_store
    import njoin_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ROW_AW-1:0] wr_addr,
    input  row_t              wr_data,
    input  logic              rd_en,
    input  logic [ROW_AW-1:0] rd_addr,
    output row_t              rd_data
);

    row_t mem [ROWS];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/njoin_row.sv =====
// ----------------------------------------------------------------------------
// njoin_row
// Row compare and compose unit, reused for every stored row of a probe.
// ----------------------------------------------------------------------------
module njoin_row
    import njoin_pkg::*;
(
    input  join_cfg_t          jcfg,
    input  row_t               left,
    input  row_t               right,
    output logic               hit,
    output logic [OCNT_W-1:0]  columns,
    output out_row_t           data
);

    logic [OCNT_W-1:0] k;

    always_comb
    begin
        hit = 1'b1;
        for (int c = 0; c < MAX_ARITY; c++)
        begin
            if ((ARITY_W'(c) < jcfg.ra) && jcfg.linked[c] &&
                (right[c] != left[jcfg.link_col[c]]))
            begin
                hit = 1'b0;
            end
        end
    end

    // left columns first, then unmatched right columns in order
    always_comb
    begin
        data = '0;
        for (int i = 0; i < MAX_ARITY; i++)
        begin
            if (ARITY_W'(i) < jcfg.la)
            begin
                data[i] = left[i];
            end
        end
        k = OCNT_W'(jcfg.la);
        for (int c = 0; c < MAX_ARITY; c++)
        begin
            if ((ARITY_W'(c) < jcfg.ra) && !jcfg.linked[c])
            begin
                data[k[OUT_IW-1:0]] = right[c];
                k = k + OCNT_W'(1);
            end
        end
        columns = k;
    end

endmodule

// ===== src/nested_loop_equi_join.sv =====
// ----------------------------------------------------------------------------
// nested_loop_equi_join
// Nested-loop equi-join engine over a stored right table.
// ----------------------------------------------------------------------------
// Clear, append and unknown-kind transactions each give one status result.
// A probe walks the stored right rows one per cycle, unless the output side
// stalls, through the single read port of the row store and the one
// compare/compose unit. Matching rows come out in stored order; the last
// one carries last=1, and a probe that matches nothing gives one no-match
// result. One match is held back in a pending register until the next
// match or the end of the scan decides whether it is the last. Input is
// not taken during a probe. Configuration (arities, match codes) is read
// at probe time, so rows loaded earlier are joined under the current
// setup. Appends into a full store are dropped with a store-full status.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module nested_loop_equi_join
    import njoin_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    njoin_in_if.sink          in_ch,
    njoin_out_if.source       out_ch,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    // configuration registers
    logic [ARITY_W-1:0] left_arity_reg;
    logic [ARITY_W-1:0] right_arity_reg;
    logic [MATCH_W-1:0] right_match_reg;
    join_cfg_t          jcfg;

    // sequencer state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    row_t               vals_reg;

    // pending match, not yet known to be last
    logic               pend_valid_reg, pend_valid_next;
    logic [OCNT_W-1:0]  pend_cols_reg, pend_cols_next;
    out_row_t           pend_data_reg, pend_data_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [OCNT_W-1:0]  out_cols_reg, out_cols_next;
    logic               out_last_reg, out_last_next;
    out_row_t           out_data_reg, out_data_next;

    // handshake and sequencing controls
    logic               out_busy;
    logic               in_ready;
    logic               in_fire;
    logic               more_rows;
    logic               stall;
    logic               advance;
    logic               issue;
    logic               scan_done;
    logic               flush_go;
    logic               store_full;

    row_t               in_row;
    row_t               rd_row;
    logic               row_hit;
    logic               hit;
    logic [OCNT_W-1:0]  row_cols;
    out_row_t           row_data;

    assign in_row = {in_ch.value_3, in_ch.value_2, in_ch.value_1, in_ch.value_0};
    assign jcfg   = decode_cfg(left_arity_reg, right_arity_reg, right_match_reg);
    assign store_full = (count_reg == CNT_W'(ROWS));

    // ------------------------------------------------------------------------
    // configuration writes; index 3 is ignored
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_arity_reg  <= ARITY_W'(1);
            right_arity_reg <= ARITY_W'(1);
            right_match_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_ARITY:  left_arity_reg  <= cfg_data[ARITY_W-1:0];
                CFG_RIGHT_ARITY: right_arity_reg <= cfg_data[ARITY_W-1:0];
                CFG_RIGHT_MATCH: right_match_reg <= cfg_data[MATCH_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // row store and the shared compare/compose unit
    // ------------------------------------------------------------------------
    njoin_store u_store
    (
        .clk     (clk),
        .wr_en   (in_fire && (in_ch.kind == KIND_APPEND) && !store_full),
        .wr_addr (count_reg[ROW_AW-1:0]),
        .wr_data (in_row),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[ROW_AW-1:0]),
        .rd_data (rd_row)
    );

    njoin_row u_row
    (
        .jcfg    (jcfg),
        .left    (vals_reg),
        .right   (rd_row),
        .hit     (row_hit),
        .columns (row_cols),
        .data    (row_data)
    );

    // ------------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_busy  = out_valid_reg && !out_ch.ready;
        in_ready  = (state_reg == ST_IDLE) && !out_busy;
        in_fire   = in_ch.valid && in_ready;
        more_rows = (rd_idx_reg < count_reg);
        hit       = rd_pend_reg && row_hit;
        // a second match needs the output register to take the held one
        stall     = hit && pend_valid_reg && out_busy;
        advance   = (state_reg == ST_SCAN) && !stall;
        issue     = advance && more_rows;
        scan_done = (state_reg == ST_SCAN) && !rd_pend_reg && !more_rows;
        flush_go  = (state_reg == ST_FLUSH) && !out_busy;
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.kind == KIND_PROBE))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (flush_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = rd_pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_cols_next  = pend_cols_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_cols_next   = out_cols_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;

        if (in_fire)
        begin
            case (in_ch.kind)
                KIND_PROBE:
                begin
                    rd_idx_next     = '0;
                    rd_pend_next    = 1'b0;
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_cols_next   = '0;
                    out_last_next   = 1'b1;
                    out_data_next   = '0;
                    if (in_ch.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (in_ch.kind == KIND_APPEND)
                    begin
                        if (store_full)
                            out_status_next = STAT_FULL;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                end
            endcase
        end

        if (advance)
        begin
            rd_pend_next = issue;
            if (issue)
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            if (hit)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_JOIN;
                    out_cols_next   = pend_cols_reg;
                    out_last_next   = 1'b0;
                    out_data_next   = pend_data_reg;
                end
                pend_valid_next = 1'b1;
                pend_cols_next  = row_cols;
                pend_data_next  = row_data;
            end
        end

        if (flush_go)
        begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_status_next = STAT_JOIN;
                out_cols_next   = pend_cols_reg;
                out_data_next   = pend_data_reg;
            end
            else
            begin
                out_status_next = STAT_NONE;
                out_cols_next   = '0;
                out_data_next   = '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.kind == KIND_PROBE))
        begin
            vals_reg <= in_row;
        end
        pend_cols_reg  <= pend_cols_next;
        pend_data_reg  <= pend_data_next;
        out_status_reg <= out_status_next;
        out_cols_reg   <= out_cols_next;
        out_last_reg   <= out_last_next;
        out_data_reg   <= out_data_next;
    end

    // ------------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------------
    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.status  = out_status_reg;
    assign out_ch.columns = out_cols_reg;
    assign out_ch.last    = out_last_reg;
    assign out_ch.out_0   = out_data_reg[0];
    assign out_ch.out_1   = out_data_reg[1];
    assign out_ch.out_2   = out_data_reg[2];
    assign out_ch.out_3   = out_data_reg[3];
    assign out_ch.out_4   = out_data_reg[4];
    assign out_ch.out_5   = out_data_reg[5];
    assign out_ch.out_6   = out_data_reg[6];
    assign out_ch.out_7   = out_data_reg[7];

`ifndef SYNTH
    // store fill never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ROWS))
        else $error("row count beyond capacity");

    // a held match never survives past the end of its probe
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending match left in idle");

    // read data is only in flight during a scan
    a_rd_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_SCAN))
        else $error("read pending outside scan");

    // end of a probe always presents a final result
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        flush_go |=> (out_valid_reg && out_last_reg))
        else $error("probe ended without last result");
`endif

endmodule

// ===== dv/nested_loop_equi_join_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nested_loop_equi_join_tb
// Self-checking bench for the equi-join engine. A mirror of the right table
// and the join setup predicts every result row. Directed tests cover the
// reset defaults, match-code rules, arity clamping and store overflow. Random
// phases follow under varied setups, with random gaps and stalls on both
// channels. Results are checked in order as they are handed off.
// ----------------------------------------------------------------------------
module nested_loop_equi_join_tb;
    import njoin_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_IDLE      = 14;
    localparam int MAX_SHOWN     = 10;
    localparam int SETTLE_CYCLES = 8;      // idle wait in settle() once every expected result is in
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 30;
    localparam int RUN_LIMIT_NS  = 60_000_000;

    // one expected (or observed) result row
    typedef struct {
        status_t            status;
        logic [OCNT_W-1:0]  columns;
        logic               last;
        out_row_t           cols;
    } join_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    njoin_in_if  in_ch ();
    njoin_out_if out_ch ();

    nested_loop_equi_join u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Mirror of the engine: stored right rows, row count and the join setup.
    // ------------------------------------------------------------------------
    row_t               table_rows [ROWS];
    int unsigned        table_count;
    logic [ARITY_W-1:0] left_arity_cfg;
    logic [ARITY_W-1:0] right_arity_cfg;
    logic [MATCH_W-1:0] match_cfg;

    join_result_t       expected_q [$];

    // idling switches, flipped per phase so some stretches run back to back
    bit                 in_idle_on;
    bit                 out_idle_on;

    int unsigned        mismatch_count;
    int unsigned        items_sent;
    int unsigned        results_seen;
    int unsigned        joined_seen;
    int unsigned        full_seen;
    int unsigned        none_seen;
    int unsigned        setups_applied;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still outstanding", expected_q.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Small builders
    // ------------------------------------------------------------------------
    function automatic row_t mk_row(input word_t v0, input word_t v1,
                                    input word_t v2, input word_t v3);
        return {v3, v2, v1, v0};
    endfunction

    // match word: 3-bit code per right column, column 0 in the low bits
    function automatic logic [CFG_DW-1:0] mk_match(input int c0, input int c1,
                                                   input int c2, input int c3);
        return {3'(c3), 3'(c2), 3'(c1), 3'(c0)};
    endfunction

    function automatic join_result_t status_only(input status_t st);
        join_result_t r;
        r.status  = st;
        r.columns = '0;
        r.last    = 1'b1;
        r.cols    = '0;
        return r;
    endfunction

    // mostly a tiny value range so probes hit, plus the extremes and full-width noise
    function automatic word_t pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return word_t'($urandom_range(0, 3));
        else if (sel == 6)
            return 32'h8000_0000;
        else if (sel == 7)
            return 32'h7FFF_FFFF;
        else
            return word_t'($urandom);
    endfunction

    function automatic int unsigned clamp_arity(input logic [ARITY_W-1:0] a);
        if (a == '0)
            return 1;
        if (a > MAX_ARITY)
            return MAX_ARITY;
        return 32'(a);
    endfunction

    // append one expectation at the tail of the queue
    function automatic void queue_expected(input join_result_t r);
        expected_q = {expected_q, r};
    endfunction

    // ------------------------------------------------------------------------
    // Join predictor: applies one accepted transaction to the mirror and
    // queues every result row it must produce.
    // ------------------------------------------------------------------------
    function automatic void join_predict(input kind_t kind, input row_t vals);
        join_result_t r;
        join_result_t hits [$];
        int unsigned  la;
        int unsigned  ra;
        int unsigned  k;
        int           code;
        int           link [MAX_ARITY];
        bit           hit;

        case (kind)
            KIND_CLEAR:
            begin
                table_count = 0;
                queue_expected(status_only(STAT_OK));
            end
            KIND_APPEND:
            begin
                if (table_count >= ROWS)
                    queue_expected(status_only(STAT_FULL));
                else
                begin
                    table_rows[table_count] = vals;
                    table_count++;
                    queue_expected(status_only(STAT_OK));
                end
            end
            KIND_PROBE:
            begin
                la = clamp_arity(left_arity_cfg);
                ra = clamp_arity(right_arity_cfg);
                // link[c]: left column that right column c must equal, -1 if free
                for (int c = 0; c < MAX_ARITY; c++)
                begin
                    code = int'(match_cfg[CODE_W*c +: CODE_W]);
                    if (code >= 1 && code <= MAX_ARITY && code - 1 < int'(la))
                        link[c] = code - 1;
                    else
                        link[c] = -1;
                end
                for (int unsigned row = 0; row < table_count; row++)
                begin
                    hit = 1'b1;
                    for (int c = 0; c < int'(ra); c++)
                        if (link[c] >= 0 && table_rows[row][c] != vals[link[c]])
                            hit = 1'b0;
                    if (hit)
                    begin
                        // left row first, then the free right columns in order
                        r.cols = '0;
                        k = 0;
                        for (int c = 0; c < int'(la); c++)
                        begin
                            r.cols[k] = vals[c];
                            k++;
                        end
                        for (int c = 0; c < int'(ra); c++)
                            if (link[c] < 0)
                            begin
                                r.cols[k] = table_rows[row][c];
                                k++;
                            end
                        r.status  = STAT_JOIN;
                        r.columns = OCNT_W'(k);
                        r.last    = 1'b0;
                        hits = {hits, r};
                    end
                end
                if (hits.size() == 0)
                    queue_expected(status_only(STAT_NONE));
                else
                begin
                    hits[hits.size() - 1].last = 1'b1;
                    foreach (hits[i])
                        queue_expected(hits[i]);
                end
            end
            default:
                queue_expected(status_only(STAT_OK));   // unknown kind: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every handed-off result is compared with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        join_result_t want;
        out_row_t     got_cols;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got_cols = {out_ch.out_7, out_ch.out_6, out_ch.out_5, out_ch.out_4,
                        out_ch.out_3, out_ch.out_2, out_ch.out_1, out_ch.out_0};
            results_seen++;
            case (status_t'(out_ch.status))
                STAT_JOIN: joined_seen++;
                STAT_FULL: full_seen++;
                STAT_NONE: none_seen++;
                default:   ;
            endcase
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: unexpected result: status %0d columns %0d last %0b",
                             $time, out_ch.status, out_ch.columns, out_ch.last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_ch.status !== want.status || out_ch.columns !== want.columns ||
                    out_ch.last !== want.last || got_cols !== want.cols)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch: expected status %0d columns %0d last %0b",
                                 $time, want.status, want.columns, want.last);
                        $display("    expected cols %h", want.cols);
                        $display("    actual   status %0d columns %0d last %0b",
                                 out_ch.status, out_ch.columns, out_ch.last);
                        $display("    actual   cols %h", got_cols);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: before each result, optionally hold ready low for a
    // random number of cycles, then keep it high until a transaction.
    // ------------------------------------------------------------------------
    initial
    begin : out_stall
        int unsigned gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    // ------------------------------------------------------------------------
    // Input side. valid stays high across back-to-back transactions, so a
    // caller must either send again in the same step or call settle().
    // ------------------------------------------------------------------------
    task automatic send_item(input kind_t kind, input row_t vals);
        int unsigned gap;
        gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.value_0 <= vals[0];
        in_ch.value_1 <= vals[1];
        in_ch.value_2 <= vals[2];
        in_ch.value_3 <= vals[3];
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        join_predict(kind, vals);
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all three registers back to back; engine must be idle
    task automatic set_config(input logic [CFG_DW-1:0] la_word,
                              input logic [CFG_DW-1:0] ra_word,
                              input logic [CFG_DW-1:0] match_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEFT_ARITY;
        cfg_data  <= la_word;
        @(posedge clk);
        left_arity_cfg = la_word[ARITY_W-1:0];
        cfg_index <= CFG_RIGHT_ARITY;
        cfg_data  <= ra_word;
        @(posedge clk);
        right_arity_cfg = ra_word[ARITY_W-1:0];
        cfg_index <= CFG_RIGHT_MATCH;
        cfg_data  <= match_word;
        @(posedge clk);
        match_cfg = match_word[MATCH_W-1:0];
        cfg_we <= 1'b0;
        setups_applied++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset setup is one left column, one right column, nothing matched.
    task automatic test_reset_defaults();
        send_item(KIND_PROBE,  mk_row(5, 0, 0, 0));              // empty store: no match
        send_item(KIND_APPEND, mk_row(7, 8, 9, 10));
        send_item(KIND_PROBE,  mk_row(32'hFFFF_FFFF, 1, 2, 3));  // product: 2 columns
        send_item(KIND_NOP,    mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
        settle();
    endtask

    // Match codes, bad codes, clamped arities and setup changed after loading.
    task automatic test_match_rules();
        // col0 = left0, col2 = left2, col3 carries bad code 7 -> free
        set_config(12'd4, 12'd4, mk_match(1, 0, 3, 7));
        send_item(KIND_CLEAR,  mk_row(0, 0, 0, 0));
        send_item(KIND_APPEND, mk_row(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF));
        send_item(KIND_APPEND, mk_row(32'h8000_0000, 1, 0, 2));
        send_item(KIND_APPEND, mk_row(32'h7FFF_FFFF, 0, 0, 0));
        send_item(KIND_PROBE,  mk_row(32'h8000_0000, 5, 0, 9));   // first two rows hit
        send_item(KIND_PROBE,  mk_row(1, 1, 1, 1));               // nothing hits
        settle();

        // left arity 0 acts as 1, right 7 as 4; code 2 names a missing left column
        set_config(12'd0, 12'd7, mk_match(2, 1, 0, 0));
        send_item(KIND_PROBE, mk_row(1, 32'h8000_0000, 3, 3));
        send_item(KIND_PROBE, mk_row(0, 32'h7FFF_FFFF, 3, 3));
        settle();

        // left 7 acts as 4, right 0 as 1; code 4 links to the last left column
        set_config(12'd7, 12'd0, mk_match(4, 0, 0, 0));
        send_item(KIND_PROBE, mk_row(0, 0, 0, 32'h7FFF_FFFF));
        send_item(KIND_PROBE, mk_row(9, 9, 9, 32'h8000_0000));
        settle();

        // junk above the arity bits; no links: full product
        set_config(12'hFF9, 12'hA03, 12'd0);
        send_item(KIND_PROBE, mk_row(32'hDEAD_BEEF, 0, 0, 0));
        settle();

        // codes 5 and 6 leave their columns free
        set_config(12'd2, 12'd4, mk_match(5, 6, 2, 0));
        send_item(KIND_PROBE, mk_row(4, 0, 4, 4));
        send_item(KIND_CLEAR, mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(KIND_PROBE, mk_row(4, 0, 4, 4));                // store empty again
        settle();
    endtask

    // Fill the store, overflow it, then probe a full table.
    task automatic test_store_full();
        row_t vals;
        int unsigned pick;
        set_config(12'd4, 12'd4, 12'd0);
        send_item(KIND_CLEAR, mk_row(0, 0, 0, 0));
        for (int i = 0; i < ROWS; i++)
            send_item(KIND_APPEND, mk_row(pick_value(), pick_value(),
                                          pick_value(), pick_value()));
        send_item(KIND_APPEND, mk_row(1, 2, 3, 4));               // dropped
        send_item(KIND_APPEND, mk_row(5, 6, 7, 8));               // dropped
        send_item(KIND_PROBE, mk_row(pick_value(), pick_value(),
                                     pick_value(), pick_value())); // 64 rows, 8 columns
        settle();   // hold off the sender until the whole product is out

        set_config(12'd4, 12'd4, mk_match(1, 2, 3, 4));
        pick = $urandom_range(0, ROWS - 1);
        vals = table_rows[pick];
        send_item(KIND_PROBE, vals);
        send_item(KIND_CLEAR, mk_row(0, 0, 0, 0));
        settle();
    endtask

    // Random phases: each under its own setup, mostly appends and probes,
    // with probes often built from a stored row so they hit.
    task automatic test_random_phases();
        logic [CFG_DW-1:0] la_word;
        logic [CFG_DW-1:0] ra_word;
        logic [CFG_DW-1:0] match_word;
        int unsigned       sel;
        int unsigned       code;
        int unsigned       pick;
        row_t              vals;
        kind_t             kind;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            in_idle_on  = (phase % 3) != 2;
            out_idle_on = (phase % 4) != 3;
            if (phase == 0)
            begin
                la_word    = CFG_DW'(4);
                ra_word    = CFG_DW'(4);
                match_word = '0;
            end
            else if (phase == 1)
            begin
                la_word    = CFG_DW'(1);
                ra_word    = CFG_DW'(1);
                match_word = 12'hFFF;
            end
            else
            begin
                la_word = CFG_DW'($urandom_range(0, 7));
                ra_word = CFG_DW'($urandom_range(0, 7));
                if ($urandom_range(0, 3) == 0)
                    la_word[CFG_DW-1:ARITY_W] = 9'($urandom);
                match_word = '0;
                for (int c = 0; c < MAX_ARITY; c++)
                begin
                    sel  = $urandom_range(0, 11);
                    code = (sel <= 7) ? sel : $urandom_range(1, 2);
                    match_word[CODE_W*c +: CODE_W] = CODE_W'(code);
                end
            end
            set_config(la_word, ra_word, match_word);

            send_item(KIND_CLEAR, mk_row(pick_value(), pick_value(),
                                         pick_value(), pick_value()));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                sel  = $urandom_range(0, 99);
                vals = mk_row(pick_value(), pick_value(), pick_value(), pick_value());
                if (sel < 4)
                    kind = KIND_CLEAR;
                else if (sel < 8)
                    kind = KIND_NOP;
                else if (sel < 52)
                    kind = KIND_APPEND;
                else
                begin
                    kind = KIND_PROBE;
                    // copy a stored row into the linked left columns
                    if (table_count != 0 && $urandom_range(0, 1) == 1)
                    begin
                        pick = $urandom_range(0, table_count - 1);
                        for (int c = 0; c < MAX_ARITY; c++)
                        begin
                            code = 32'(match_cfg[CODE_W*c +: CODE_W]);
                            if (code >= 1 && code <= MAX_ARITY)
                                vals[code - 1] = table_rows[pick][c];
                        end
                    end
                end
                send_item(kind, vals);
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_LEFT_ARITY;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.kind    <= KIND_CLEAR;
        in_ch.value_0 <= '0;
        in_ch.value_1 <= '0;
        in_ch.value_2 <= '0;
        in_ch.value_3 <= '0;

        // mirror starts at the reset setup
        table_count     = 0;
        left_arity_cfg  = ARITY_W'(1);
        right_arity_cfg = ARITY_W'(1);
        match_cfg       = '0;
        in_idle_on      = 1'b1;
        out_idle_on     = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_match_rules();
        test_store_full();
        test_random_phases();

        settle();
        $display("covered %0d input transactions and %0d results under %0d setups",
                 items_sent, results_seen, setups_applied);
        $display("results: %0d joined rows, %0d store-full drops, %0d no-match probes",
                 joined_seen, full_seen, none_seen);
        if (mismatch_count == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
